// ----- design/rsq_pkg.sv -----
package rsq_pkg;

  // Field widths of the stream payloads
  localparam int SENDER_W = 6;
  localparam int SEQ_W    = 32;
  localparam int PAY_W    = 32;
  localparam int DATA_W   = 72;

  // Bit positions of the fields inside tdata
  localparam int SENDER_LSB = 0;
  localparam int SEQ_LSB    = SENDER_LSB + SENDER_W;
  localparam int PAY_LSB    = SEQ_LSB + SEQ_W;

  // Defaults of the top-level parameters
  localparam int NUM_SENDERS_DEF = 8;
  localparam int WINDOW_DEF      = 16;

  // Most results one request may cause, and a counter able to hold that figure
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // Depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;

  // Request as it travels from the front part to the back part
  typedef struct packed {
    logic                bad;
    logic [SENDER_W-1:0] sender;
    logic [SEQ_W-1:0]    seq_no;
    logic [PAY_W-1:0]    payload;
  } item_t;

  // One released or dropped message
  typedef struct packed {
    logic [SENDER_W-1:0] sender;
    logic [SEQ_W-1:0]    seq_no;
    logic [PAY_W-1:0]    payload;
    logic                dropped;
  } result_t;

endpackage

// ----- design/rsq_ram.sv -----
module rsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port that holds its data between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/rsq_front.sv -----
module rsq_front #(
  parameter int NUM_SENDERS = rsq_pkg::NUM_SENDERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_valid,
  output logic                       s_ready,
  input  logic [rsq_pkg::DATA_W-1:0] s_data,
  output logic                       q_valid,
  input  logic                       q_ready,
  output rsq_pkg::item_t             q_item
);

  localparam int QAW = $clog2(rsq_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(rsq_pkg::QUEUE_DEPTH + 1);

  rsq_pkg::item_t entries [rsq_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  rsq_pkg::item_t in_item;
  logic           push;
  logic           pop;

  // Unpack the request and mark a sender outside the configured range
  always_comb begin
    in_item.sender  = s_data[rsq_pkg::SENDER_LSB +: rsq_pkg::SENDER_W];
    in_item.seq_no  = s_data[rsq_pkg::SEQ_LSB +: rsq_pkg::SEQ_W];
    in_item.payload = s_data[rsq_pkg::PAY_LSB +: rsq_pkg::PAY_W];
    in_item.bad     = ({1'b0, in_item.sender} >= (rsq_pkg::SENDER_W + 1)'(NUM_SENDERS));
  end

  assign s_ready = (count != QCW'(rsq_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = q_valid && q_ready;

  // Queue storage, written only on an accepted request
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(rsq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(rsq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/rsq_back.sv -----
module rsq_back #(
  parameter int NUM_SENDERS = rsq_pkg::NUM_SENDERS_DEF,
  parameter int WINDOW      = rsq_pkg::WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  rsq_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output rsq_pkg::result_t out_res,
  output logic             out_last
);

  localparam int SNDW   = $clog2(NUM_SENDERS);
  localparam int SW     = $clog2(WINDOW);
  localparam int SUMW   = SW + 2;
  localparam int STW    = rsq_pkg::SEQ_W + SW + WINDOW;
  localparam int PDEPTH = NUM_SENDERS * (2 ** SW);
  localparam longint unsigned TWO32 = 64'h1_0000_0000;
  // Shift of the slot index when a window straddles the wrap of the numbers
  localparam int WRAP_ADJ = int'((WINDOW - (TWO32 % WINDOW)) % WINDOW);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOKUP, S_DRAIN, S_DRAIN_RD, S_FIN
  } state_t;

  typedef enum logic [1:0] {C_OLD, C_EXP, C_AHEAD, C_FAR} cls_t;

  state_t           state;
  rsq_pkg::item_t   item_r;
  logic [31:0]      ne;
  logic [SW-1:0]    nm;
  logic [WINDOW-1:0] mask;
  logic [rsq_pkg::CNT_W-1:0] n;
  logic [31:0]      dseq;
  logic             pend_valid;
  rsq_pkg::result_t pend;
  logic [NUM_SENDERS-1:0] init;

  logic [SNDW-1:0]  snd_idx;
  logic [STW-1:0]   st_q;
  logic [STW-1:0]   st_wdata;
  logic             st_re;
  logic             st_we;
  logic [31:0]      cur_ne;
  logic [SW-1:0]    cur_nm;
  logic [WINDOW-1:0] cur_mask;
  logic [31:0]      d;
  cls_t             cls;
  logic [SUMW-1:0]  sum0;
  logic [SUMW-1:0]  sum1;
  logic [SUMW-1:0]  sum2;
  logic [SW-1:0]    slot;
  logic             slot_busy;
  logic             need_res;
  logic             out_free;
  logic             gen_ok;
  logic             lookup_go;
  logic             drain_go;
  logic             fin_go;
  logic             gen_en;
  rsq_pkg::result_t gen_res;
  logic             p_we;
  logic             p_re;
  logic [rsq_pkg::PAY_W-1:0] p_q;

  // Slot index of the number after ne, tracked without dividing the number
  function automatic logic [SW-1:0] nm_step(input logic [31:0] ne_val,
                                            input logic [SW-1:0] nm_val);
    logic [SW-1:0] r;
    if (ne_val == 32'hFFFF_FFFF) begin
      r = '0;
    end else if (nm_val == SW'(WINDOW - 1)) begin
      r = '0;
    end else begin
      r = nm_val + 1'b1;
    end
    return r;
  endfunction

  assign snd_idx = item_r.sender[SNDW-1:0];

  // Sender state word; a sender never written reads as its reset value
  always_comb begin
    if (init[snd_idx]) begin
      cur_ne   = st_q[31:0];
      cur_nm   = st_q[32 +: SW];
      cur_mask = st_q[32 + SW +: WINDOW];
    end else begin
      cur_ne   = 32'd1;
      cur_nm   = SW'(1);
      cur_mask = '0;
    end
  end

  // Classify the arrival against the expected number
  always_comb begin
    d = item_r.seq_no - cur_ne;
    if (d[31]) begin
      cls = C_OLD;
    end else if (d == '0) begin
      cls = C_EXP;
    end else if (d < 32'(WINDOW)) begin
      cls = C_AHEAD;
    end else begin
      cls = C_FAR;
    end
  end

  // Slot of an arrival ahead of the window start: seq_no modulo the window
  always_comb begin
    sum0 = SUMW'(cur_nm) + SUMW'(d[SW-1:0]) +
           ((item_r.seq_no < cur_ne) ? SUMW'(WRAP_ADJ) : '0);
    sum1 = (sum0 >= SUMW'(WINDOW)) ? sum0 - SUMW'(WINDOW) : sum0;
    sum2 = (sum1 >= SUMW'(WINDOW)) ? sum1 - SUMW'(WINDOW) : sum1;
    slot = sum2[SW-1:0];
    slot_busy = cur_mask[slot];
  end

  // Handshake and progress conditions of the sequencer
  always_comb begin
    need_res  = (cls != C_AHEAD) || slot_busy;
    out_free  = !out_valid || out_ready;
    gen_ok    = !pend_valid || out_free;
    lookup_go = (state == S_LOOKUP) && (!need_res || gen_ok);
    drain_go  = (state == S_DRAIN) && mask[nm] && (n < rsq_pkg::CNT_W'(rsq_pkg::MAX_OUT));
    fin_go    = (state == S_FIN) && (!pend_valid || out_free);
    q_ready   = (state == S_IDLE);
    st_re     = (state == S_IDLE) && q_valid && !q_item.bad;
    st_we     = fin_go && !item_r.bad;
    st_wdata  = {mask, nm, ne};
    p_we      = lookup_go && (cls == C_AHEAD) && !slot_busy;
    p_re      = drain_go;
  end

  // Result created this cycle, if any
  always_comb begin
    gen_en = 1'b0;
    gen_res.sender = item_r.sender;
    gen_res.seq_no = item_r.seq_no;
    gen_res.payload = item_r.payload;
    gen_res.dropped = (cls == C_AHEAD) || (cls == C_FAR);
    if (state == S_LOOKUP) begin
      gen_en = lookup_go && need_res;
    end else if (state == S_DRAIN_RD) begin
      gen_en = gen_ok;
      gen_res.seq_no  = dseq;
      gen_res.payload = p_q;
      gen_res.dropped = 1'b0;
    end
  end

  // Sequencer with the pending result and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      init       <= '0;
      n          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item_r <= q_item;
            n      <= '0;
            if (q_item.bad) begin
              pend.sender  <= q_item.sender;
              pend.seq_no  <= q_item.seq_no;
              pend.payload <= q_item.payload;
              pend.dropped <= 1'b1;
              pend_valid   <= 1'b1;
              state        <= S_FIN;
            end else begin
              state <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          if (lookup_go) begin
            if (cls == C_EXP) begin
              ne <= cur_ne + 1'b1;
              nm <= nm_step(cur_ne, cur_nm);
            end else begin
              ne <= cur_ne;
              nm <= cur_nm;
            end
            mask  <= (p_we) ? (cur_mask | (WINDOW'(1) << slot)) : cur_mask;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_go) begin
            mask[nm] <= 1'b0;
            dseq     <= ne;
            ne       <= ne + 1'b1;
            nm       <= nm_step(ne, nm);
            state    <= S_DRAIN_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_DRAIN_RD: begin
          if (gen_ok) begin
            state <= S_DRAIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (pend_valid) begin
              out_res    <= pend;
              out_last   <= 1'b1;
              pend_valid <= 1'b0;
            end
            if (!item_r.bad) begin
              init[snd_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // A new result pushes the earlier one out; only the final one is marked
      if (gen_en) begin
        if (pend_valid) begin
          out_res   <= pend;
          out_last  <= 1'b0;
        end
        pend       <= gen_res;
        pend_valid <= 1'b1;
        n          <= n + 1'b1;
      end
      // The output register fills when the pending result moves on and empties when taken
      if ((gen_en || fin_go) && pend_valid) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-sender state: expected number, its slot index and the parked mask
  rsq_ram #(
    .WIDTH(STW),
    .DEPTH(NUM_SENDERS)
  ) u_state_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(snd_idx),
    .wdata(st_wdata),
    .re   (st_re),
    .raddr(q_item.sender[SNDW-1:0]),
    .rdata(st_q)
  );

  // Parked payloads, one row of slots per sender
  rsq_ram #(
    .WIDTH(rsq_pkg::PAY_W),
    .DEPTH(PDEPTH)
  ) u_payload_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr({snd_idx, slot}),
    .wdata(item_r.payload),
    .re   (p_re),
    .raddr({snd_idx, nm}),
    .rdata(p_q)
  );

endmodule

// ----- design/fifo_resequencer_top.sv -----
// Per-sender resequencer for a message stream.
// Requests arrive on the s_axis channel: sender index, sequence number and
// payload. Results leave on the m_axis channel with the same fields; tuser
// flags a request that was dropped (beyond the window, slot already taken or
// unknown sender) and tlast marks the final result caused by a request.
// A message at or below its sender's expected number is released at once; a
// message a little ahead is parked until the gap closes, and then released
// together with every following parked message, up to 16 results a request.
// A four-entry queue parts the accepting front from the sequencer, so
// requests are taken while the sequencer works or the output waits.
// A request passes the sequencer states idle, lookup, drain and finish, with
// a drain and a read step for each parked message it releases (idle and
// finish only for an unknown sender); the lookup and read steps wait on the
// registered reads of the sender state memory and the payload memory. A
// result is held back in the pending register until it is known whether it
// is the last. When the receiver stalls, the output register and the pending
// result hold, the sequencer waits, and the queue fills before s_axis_tready
// falls. Reset empties the queue and marks every sender as expecting number
// 1 with no message parked; no clearing pass is needed.
module fifo_resequencer_top #(
  parameter int NUM_SENDERS = rsq_pkg::NUM_SENDERS_DEF,
  parameter int WINDOW      = rsq_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // origin_sender [5:0], seq_no [37:6], payload [69:38], zero [71:70]
  input  logic [rsq_pkg::DATA_W-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // out_sender [5:0], out_seq_no [37:6], out_payload [69:38], zero [71:70]
  output logic [rsq_pkg::DATA_W-1:0] m_axis_tdata,
  // dropped [0]
  output logic [0:0]                 m_axis_tuser,
  output logic                       m_axis_tlast
);

  logic             q_valid;
  logic             q_ready;
  rsq_pkg::item_t   q_item;
  rsq_pkg::result_t out_res;

  // Front: accepts and classifies requests into the queue
  rsq_front #(
    .NUM_SENDERS(NUM_SENDERS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .s_valid(s_axis_tvalid),
    .s_ready(s_axis_tready),
    .s_data (s_axis_tdata),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_item (q_item)
  );

  // Back: per-sender ordering, parking and release
  rsq_back #(
    .NUM_SENDERS(NUM_SENDERS),
    .WINDOW     (WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res),
    .out_last (m_axis_tlast)
  );

  // Pack the result fields from the lowest bit up
  assign m_axis_tdata = {2'b00, out_res.payload, out_res.seq_no, out_res.sender};
  assign m_axis_tuser = out_res.dropped;

endmodule
